[design/bcs_pkg.sv]
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared constants and the command/status bundles that join the controller
// and the datapath of the bigram count-and-sample engine.
// ----------------------------------------------------------------------------
package bcs_pkg;

    // fixed field widths of the item ports
    localparam int KEY_W     = 64;
    localparam int POS_W     = 2;
    localparam int CUR_W     = 7;
    localparam int DRAW_W    = 16;
    localparam int IDX_OUT_W = 7;
    localparam int CNT_OUT_W = 8;
    localparam int STATUS_W  = 2;

    // reserved vocabulary slots
    localparam int START_SLOT = 0;
    localparam int END_SLOT   = 1;
    localparam int FIRST_FREE = 2;

    // operation codes
    localparam logic OP_TRAIN  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // sentence position codes
    localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
    localparam logic [POS_W-1:0] POS_MIDDLE = 2'd1;
    localparam logic [POS_W-1:0] POS_LAST   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_step;
        logic srch_rd;
        logic srch_next;
        logic key_add;
        logic set_full;
        logic upd_rd;
        logic upd_wr;
        logic upd_step1;
        logic train_done;
        logic tot_rd;
        logic set_empty;
        logic div_start;
        logic div_step;
        logic walk_init;
        logic walk_rd;
        logic walk_acc;
        logic set_miss;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic op_sample;
        logic pos_last;
        logic step1;
        logic srch_end;
        logic key_match;
        logic full;
        logic row_bad;
        logic div_done;
        logic walk_end;
        logic sum_hit;
        logic out_busy;
    } stat_t;

endpackage

[design/bcs_ctrl.sv]
// ----------------------------------------------------------------------------
// bcs_ctrl
// Sequencer of the engine: clearing pass, vocabulary search, count updates,
// modulo reduction and the cumulative row walk, one item at a time.
// ----------------------------------------------------------------------------
module bcs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bcs_pkg::stat_t stat,
    output bcs_pkg::cmd_t  cmd
);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_START = 13'b0000000000100,
        S_SRCH  = 13'b0000000001000,
        S_CMP   = 13'b0000000010000,
        S_NEW   = 13'b0000000100000,
        S_URD   = 13'b0000001000000,
        S_UWR   = 13'b0000010000000,
        S_TCHK  = 13'b0000100000000,
        S_DIV   = 13'b0001000000000,
        S_WRD   = 13'b0010000000000,
        S_WACC  = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (stat.op_sample) begin
                    cmd.tot_rd = 1'b1;
                    state_next = S_TCHK;
                end else begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH: begin
                if (stat.srch_end) begin
                    state_next = S_NEW;
                end else begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP: begin
                cmd.srch_next = 1'b1;
                state_next    = stat.key_match ? S_URD : S_SRCH;
            end
            S_NEW: begin
                if (stat.full) begin
                    cmd.set_full = 1'b1;
                    state_next   = S_FIN;
                end else begin
                    cmd.key_add = 1'b1;
                    state_next  = S_URD;
                end
            end
            S_URD: begin
                cmd.upd_rd = 1'b1;
                state_next = S_UWR;
            end
            S_UWR: begin
                cmd.upd_wr = 1'b1;
                if (stat.pos_last && !stat.step1) begin
                    cmd.upd_step1 = 1'b1;
                    state_next    = S_URD;
                end else begin
                    cmd.train_done = 1'b1;
                    state_next     = S_FIN;
                end
            end
            S_TCHK: begin
                if (stat.row_bad) begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_WRD;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_WRD: begin
                if (stat.walk_end) begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_FIN;
                end else begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_WACC;
                end
            end
            S_WACC: begin
                cmd.walk_acc = 1'b1;
                state_next   = stat.sum_hit ? S_FIN : S_WRD;
            end
            S_FIN: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_CLEAR;
        else          state_reg <= state_next;
    end

endmodule

[design/bcs_datapath.sv]
// ----------------------------------------------------------------------------
// bcs_datapath
// Key, count and total memories, item registers, vocabulary bookkeeping,
// bit-serial modulo unit, walk accumulator and the result register.
// ----------------------------------------------------------------------------
module bcs_datapath #(
    parameter int VOCAB_SIZE  = 128,
    parameter int COUNT_WIDTH = 16,
    parameter int KEY_BYTES   = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bcs_pkg::cmd_t                      cmd,
    output bcs_pkg::stat_t                     stat,
    input  logic                               s_op,
    input  logic [bcs_pkg::KEY_W-1:0]          s_word_key,
    input  logic [bcs_pkg::POS_W-1:0]          s_position,
    input  logic [bcs_pkg::CUR_W-1:0]          s_current_index,
    input  logic [bcs_pkg::DRAW_W-1:0]         s_random_draw,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bcs_pkg::IDX_OUT_W-1:0]      m_word_index,
    output logic [bcs_pkg::STATUS_W-1:0]       m_status,
    output logic [bcs_pkg::CNT_OUT_W-1:0]      m_vocab_count
);

    localparam int IW    = $clog2(VOCAB_SIZE);
    localparam int UW    = $clog2(VOCAB_SIZE + 1);
    localparam int AW    = (UW > bcs_pkg::CUR_W) ? UW : bcs_pkg::CUR_W;
    localparam int PAW   = $clog2(VOCAB_SIZE * VOCAB_SIZE);
    localparam int CW    = COUNT_WIDTH;
    localparam int RW    = COUNT_WIDTH + 1;
    localparam int SW    = COUNT_WIDTH + IW + 1;
    localparam int DCW   = $clog2(bcs_pkg::DRAW_W + 1);
    localparam int KW    = bcs_pkg::KEY_W;

    // memories
    logic [KW-1:0] key_mem  [VOCAB_SIZE];
    logic [CW-1:0] pair_mem [VOCAB_SIZE * VOCAB_SIZE];
    logic [CW-1:0] tot_mem  [VOCAB_SIZE];

    // item and working registers
    logic                           op_reg;
    logic [KW-1:0]                  key_reg;
    logic [bcs_pkg::POS_W-1:0]      pos_reg;
    logic [bcs_pkg::CUR_W-1:0]      a_reg;
    logic [bcs_pkg::DRAW_W-1:0]     draw_reg;
    logic [UW-1:0]                  used_reg;
    logic [IW-1:0]                  prev_reg;
    logic [UW-1:0]                  ptr_reg;
    logic [UW-1:0]                  k_reg;
    logic [IW-1:0]                  w_reg;
    logic                           step_reg;
    logic [RW-1:0]                  rem_reg;
    logic [DCW-1:0]                 dcnt_reg;
    logic [SW-1:0]                  sum_reg;
    logic [PAW-1:0]                 clr_reg;
    logic [KW-1:0]                  key_rd_reg;
    logic [CW-1:0]                  pair_rd_reg;
    logic [CW-1:0]                  tot_rd_reg;
    logic [bcs_pkg::IDX_OUT_W-1:0]  res_idx_reg;
    logic [bcs_pkg::STATUS_W-1:0]   res_st_reg;
    logic                           m_valid_reg;
    logic [bcs_pkg::IDX_OUT_W-1:0]  m_idx_reg;
    logic [bcs_pkg::STATUS_W-1:0]   m_st_reg;
    logic [bcs_pkg::CNT_OUT_W-1:0]  m_cnt_reg;

    logic [KW-1:0]  canon_key;
    logic [IW-1:0]  a_idx;
    logic [IW-1:0]  upd_row;
    logic [IW-1:0]  upd_col;
    logic [IW-1:0]  tot_row;
    logic [PAW-1:0] upd_addr;
    logic [PAW-1:0] walk_addr;
    logic [PAW-1:0] pair_raddr;
    logic [IW-1:0]  tot_raddr;
    logic [RW-1:0]  rem_shift;
    logic [SW-1:0]  sum_next;
    logic [SW-1:0]  lim;
    logic [UW-1:0]  ptr_inc;
    logic [UW-1:0]  a_inc;

    // key ends at its first zero byte, only the low KEY_BYTES bytes count
    always_comb begin
        logic stop;
        stop      = 1'b0;
        canon_key = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < KEY_BYTES && !stop) begin
                if (s_word_key[8*i +: 8] == 8'd0) stop = 1'b1;
                else canon_key[8*i +: 8] = s_word_key[8*i +: 8];
            end
        end
    end

    assign a_idx = IW'(a_reg);

    // count update addressing by sentence position
    always_comb begin
        case (pos_reg)
            bcs_pkg::POS_FIRST: begin
                upd_row = IW'(bcs_pkg::START_SLOT);
                upd_col = w_reg;
                tot_row = IW'(bcs_pkg::START_SLOT);
            end
            bcs_pkg::POS_LAST: begin
                upd_row = step_reg ? IW'(bcs_pkg::END_SLOT) : w_reg;
                upd_col = step_reg ? w_reg : IW'(bcs_pkg::END_SLOT);
                tot_row = IW'(bcs_pkg::END_SLOT);
            end
            default: begin
                upd_row = prev_reg;
                upd_col = w_reg;
                tot_row = prev_reg;
            end
        endcase
    end

    assign upd_addr   = PAW'(upd_row) * PAW'(VOCAB_SIZE) + PAW'(upd_col);
    assign walk_addr  = PAW'(a_idx) * PAW'(VOCAB_SIZE) + PAW'(ptr_reg);
    assign pair_raddr = cmd.walk_rd ? walk_addr : upd_addr;
    assign tot_raddr  = cmd.tot_rd ? a_idx : tot_row;

    // modulo step, walk sums and wrap
    assign rem_shift = {rem_reg[RW-2:0], draw_reg[bcs_pkg::DRAW_W-1]};
    assign sum_next  = sum_reg + SW'(pair_rd_reg);
    assign lim       = SW'(rem_reg) + SW'(1);
    assign ptr_inc   = (ptr_reg + UW'(1) == used_reg) ? '0 : ptr_reg + UW'(1);
    assign a_inc     = (UW'(a_reg) + UW'(1) == used_reg) ? '0 : UW'(a_reg) + UW'(1);

    // key memory
    always_ff @(posedge aclk) begin
        if (cmd.key_add) key_mem[IW'(used_reg)] <= key_reg;
        if (cmd.srch_rd) key_rd_reg <= key_mem[IW'(ptr_reg)];
    end

    // pair count memory
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            pair_mem[clr_reg] <= '0;
        end else if (cmd.upd_wr) begin
            pair_mem[upd_addr] <= (pair_rd_reg == '1) ? pair_rd_reg : pair_rd_reg + CW'(1);
        end
        pair_rd_reg <= pair_mem[pair_raddr];
    end

    // row total memory, read data held while the modulo unit runs
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            if (clr_reg < PAW'(VOCAB_SIZE)) tot_mem[IW'(clr_reg)] <= '0;
        end else if (cmd.upd_wr && !step_reg) begin
            tot_mem[tot_row] <= (tot_rd_reg == '1) ? tot_rd_reg : tot_rd_reg + CW'(1);
        end
        if (cmd.tot_rd || cmd.upd_rd) tot_rd_reg <= tot_mem[tot_raddr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= UW'(bcs_pkg::FIRST_FREE);
            prev_reg    <= IW'(bcs_pkg::START_SLOT);
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_step) clr_reg <= clr_reg + PAW'(1);
            if (cmd.key_add) used_reg <= used_reg + UW'(1);
            if (cmd.train_done) prev_reg <= w_reg;
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // item and working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_op;
            key_reg  <= canon_key;
            pos_reg  <= s_position;
            a_reg    <= s_current_index;
            draw_reg <= s_random_draw;
            ptr_reg  <= UW'(bcs_pkg::FIRST_FREE);
            step_reg <= 1'b0;
        end
        // vocabulary search
        if (cmd.srch_next) begin
            if (key_rd_reg == key_reg) w_reg <= IW'(ptr_reg);
            else ptr_reg <= ptr_reg + UW'(1);
        end
        if (cmd.key_add) w_reg <= IW'(used_reg);
        if (cmd.upd_step1) step_reg <= 1'b1;
        // modulo of the draw by the row total, one bit a cycle
        if (cmd.div_start) begin
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= (rem_shift >= RW'(tot_rd_reg)) ? rem_shift - RW'(tot_rd_reg)
                                                       : rem_shift;
            draw_reg <= draw_reg << 1;
            dcnt_reg <= dcnt_reg + DCW'(1);
        end
        // cumulative walk
        if (cmd.walk_init) begin
            ptr_reg <= a_inc;
            k_reg   <= UW'(1);
            sum_reg <= '0;
        end
        if (cmd.walk_acc) begin
            sum_reg <= sum_next;
            ptr_reg <= ptr_inc;
            k_reg   <= k_reg + UW'(1);
            if (sum_next >= lim) begin
                res_idx_reg <= bcs_pkg::IDX_OUT_W'(ptr_reg);
                res_st_reg  <= bcs_pkg::ST_OK;
            end
        end
        // result selection
        if (cmd.set_full) begin
            res_idx_reg <= '0;
            res_st_reg  <= bcs_pkg::ST_FULL;
        end
        if (cmd.train_done) begin
            res_idx_reg <= bcs_pkg::IDX_OUT_W'(w_reg);
            res_st_reg  <= bcs_pkg::ST_OK;
        end
        if (cmd.set_empty) begin
            res_idx_reg <= a_reg;
            res_st_reg  <= bcs_pkg::ST_EMPTY;
        end
        if (cmd.set_miss) begin
            res_idx_reg <= a_reg;
            res_st_reg  <= bcs_pkg::ST_OK;
        end
        // output register
        if (cmd.out_load) begin
            m_idx_reg <= res_idx_reg;
            m_st_reg  <= res_st_reg;
            m_cnt_reg <= bcs_pkg::CNT_OUT_W'(used_reg);
        end
    end

    // status to the controller
    always_comb begin
        stat           = '0;
        stat.clr_last  = (clr_reg == PAW'(VOCAB_SIZE * VOCAB_SIZE - 1));
        stat.op_sample = (op_reg == bcs_pkg::OP_SAMPLE);
        stat.pos_last  = (pos_reg == bcs_pkg::POS_LAST);
        stat.step1     = step_reg;
        stat.srch_end  = (ptr_reg == used_reg);
        stat.key_match = (key_rd_reg == key_reg);
        stat.full      = (used_reg >= UW'(VOCAB_SIZE));
        stat.row_bad   = (AW'(a_reg) >= AW'(used_reg)) || (tot_rd_reg == '0);
        stat.div_done  = (dcnt_reg == DCW'(bcs_pkg::DRAW_W));
        stat.walk_end  = (k_reg == used_reg);
        stat.sum_hit   = (sum_next >= lim);
        stat.out_busy  = m_valid_reg && !m_ready;
    end

    assign m_valid       = m_valid_reg;
    assign m_word_index  = m_idx_reg;
    assign m_status      = m_st_reg;
    assign m_vocab_count = m_cnt_reg;

endmodule

[design/bigram_count_and_sample.sv]
// ----------------------------------------------------------------------------
// bigram_count_and_sample
// Bigram table engine: trains word transition counts and samples successors.
// ----------------------------------------------------------------------------
// After reset the engine clears its VOCAB_SIZE x VOCAB_SIZE count memory and
// the row totals, one entry a cycle, and takes no item until done. Items are
// then handled one at a time. A train item searches the vocabulary entry by
// entry, then handles the lookup end, a new slot and the count updates; a
// sample item runs the 16-step modulo unit and then walks the row entry by
// entry. One result is returned per item; the next item is taken while a
// result waits in the output register.
module bigram_count_and_sample #(
    parameter int VOCAB_SIZE  = 128,
    parameter int COUNT_WIDTH = 16,
    parameter int KEY_BYTES   = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_op,
    input  logic [bcs_pkg::KEY_W-1:0]          s_word_key,
    input  logic [bcs_pkg::POS_W-1:0]          s_position,
    input  logic [bcs_pkg::CUR_W-1:0]          s_current_index,
    input  logic [bcs_pkg::DRAW_W-1:0]         s_random_draw,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bcs_pkg::IDX_OUT_W-1:0]      m_word_index,
    output logic [bcs_pkg::STATUS_W-1:0]       m_status,
    output logic [bcs_pkg::CNT_OUT_W-1:0]      m_vocab_count
);

    bcs_pkg::cmd_t  cmd;
    bcs_pkg::stat_t stat;

    // sequencer
    bcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // memories and arithmetic
    bcs_datapath #(
        .VOCAB_SIZE  (VOCAB_SIZE),
        .COUNT_WIDTH (COUNT_WIDTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_op            (s_op),
        .s_word_key      (s_word_key),
        .s_position      (s_position),
        .s_current_index (s_current_index),
        .s_random_draw   (s_random_draw),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_word_index    (m_word_index),
        .m_status        (m_status),
        .m_vocab_count   (m_vocab_count)
    );

endmodule
